// File: design/lpms_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lpms_pkg
// Shared types and constants for the long press mode selector.
// ---------------------------------------------------------------------------
package lpms_pkg;

    localparam int unsigned THR_W     = 16;
    localparam int unsigned CNT_W     = 17;
    localparam logic [THR_W-1:0] THR_RST = THR_W'(5000);

    typedef enum logic [1:0] {
        MODE_STD   = 2'd0,
        MODE_ECO   = 2'd1,
        MODE_MAINT = 2'd2,
        MODE_CONF  = 2'd3
    } t_mode;

    typedef struct packed {
        logic green_pressed;
        logic red_pressed;
        logic force_config;
    } t_in;

    typedef struct packed {
        t_mode current_mode;
        t_mode prior_mode;
        logic  mode_changed;
    } t_out;

endpackage

`default_nettype wire

// File: design/lpms_button.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lpms_button
// Hold tracker for one button: held flag, saturating hold count and a
// one-shot done flag; fires once per press when the count passes threshold.
// ---------------------------------------------------------------------------
module lpms_button
    import lpms_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_level,
    input  wire logic [THR_W-1:0] i_threshold,
    output logic                  o_fire
);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic             r_held, n_held;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_held  = r_held;
        n_done  = r_done;
        n_count = r_count;
        if (i_level) begin
            if (!r_held) begin
                n_held  = 1'b1;
                n_count = '0;
                n_done  = 1'b0;
            end else if (r_count != CNT_MAX) begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (r_held) begin
            n_held = 1'b0;
            n_done = 1'b0;
        end
        o_fire = n_held && !n_done && (n_count > CNT_W'(i_threshold));
        if (o_fire) begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            r_held  <= n_held;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: design/long_press_mode_selector_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// long_press_mode_selector_core
// Mode selector driven by long presses of a green and a red button.
// ---------------------------------------------------------------------------
// Each input transfer is one millisecond tick and yields exactly one result
// transfer, offered next cycle. The tick is handled combinationally: both
// button trackers and the mode update sit between the input port and the
// result register, so a new tick is taken every cycle as long as the result
// register is empty or is being drained in the same cycle. hold_threshold
// is written through i_cfg_we / i_cfg_wdata and resets to 5000.
module long_press_mode_selector_core
    import lpms_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata
);

    logic [THR_W-1:0] r_threshold;
    t_mode            r_mode, n_mode;
    t_mode            r_saved, n_saved;
    logic             n_changed;
    logic             r_out_valid;
    t_out             r_out_data;
    logic             w_accept;
    logic             w_green_fire;
    logic             w_red_fire;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RST;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    lpms_button u_green (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_level     (i_in_data.green_pressed),
        .i_threshold (r_threshold),
        .o_fire      (w_green_fire)
    );

    lpms_button u_red (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_level     (i_in_data.red_pressed),
        .i_threshold (r_threshold),
        .o_fire      (w_red_fire)
    );

    // green first, then red, then the force strobe
    always_comb begin
        n_mode    = r_mode;
        n_saved   = r_saved;
        n_changed = 1'b0;
        if (w_green_fire) begin
            if (n_mode == MODE_STD) begin
                n_saved   = MODE_STD;
                n_mode    = MODE_ECO;
                n_changed = 1'b1;
            end else if (n_mode == MODE_ECO) begin
                n_saved   = MODE_ECO;
                n_mode    = MODE_STD;
                n_changed = 1'b1;
            end
        end
        if (w_red_fire) begin
            if (n_mode != MODE_MAINT) begin
                n_saved = n_mode;
                n_mode  = MODE_MAINT;
            end else begin
                n_mode  = n_saved;
                n_saved = MODE_MAINT;
            end
            n_changed = 1'b1;
        end
        if (i_in_data.force_config) begin
            n_saved   = n_mode;
            n_mode    = MODE_CONF;
            n_changed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STD;
            r_saved     <= MODE_STD;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mode      <= n_mode;
                r_saved     <= n_saved;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data.current_mode <= n_mode;
            r_out_data.prior_mode   <= n_saved;
            r_out_data.mode_changed <= n_changed;
        end
    end

`ifndef SYNTHESIS
    a_force_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_data.force_config |=>
            r_mode == MODE_CONF && r_out_data.mode_changed)
        else $error("force strobe did not enter configuration mode");

    a_no_change_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !n_changed && !w_red_fire |=> $stable(r_mode))
        else $error("mode moved on a tick without a change");

    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.current_mode == r_mode
            && o_out_data.prior_mode == r_saved)
        else $error("result disagrees with mode state");

    a_idle_mode_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_mode) && $stable(r_saved))
        else $error("mode state changed without an input transfer");
`endif

endmodule

`default_nettype wire
